[rtl/core/ladr_pkg.sv]
package ladr_pkg;

   localparam int HISTORY_DEPTH = 8;
   localparam int RING_IDX_W    = $clog2(HISTORY_DEPTH);
   localparam int SNR_W         = 8;
   localparam int SUM_W         = SNR_W + RING_IDX_W;
   localparam int MARGIN_W      = SUM_W + 1;
   localparam int SPREAD_W      = SNR_W + 2;
   localparam int NIBBLE_W      = 4;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int REQ_DATA_W    = 16;
   localparam int REQ_USER_W    = 3;
   localparam int RSP_DATA_W    = 40;

   localparam logic signed [SNR_W-1:0]    RING_FILL_SNR = -8'sd30;
   localparam logic signed [SNR_W-1:0]    HI_START     = -8'sd40;
   localparam logic signed [SNR_W-1:0]    LO_START     = 8'sd40;
   localparam logic signed [SPREAD_W-1:0] SPREAD_LIMIT = SPREAD_W'(4);
   localparam logic signed [MARGIN_W-1:0] RATE_STEP    = MARGIN_W'(5 * HISTORY_DEPTH);
   localparam logic signed [MARGIN_W-1:0] POWER_STEP   = MARGIN_W'(6 * HISTORY_DEPTH);
   localparam logic [7:0]                 LINK_ADR_REQ = 8'h03;
   localparam logic [7:0]                 REDUNDANCY   = 8'h00;

   localparam logic [NIBBLE_W-1:0]   RATE_LIMIT_RST    = 4'd5;
   localparam logic [NIBBLE_W-1:0]   POWER_LIMIT_RST   = 4'd7;
   localparam logic [NIBBLE_W-1:0]   DEFAULT_POWER_RST = 4'd0;
   localparam logic [NIBBLE_W-1:0]   EXCLUDED_RATE_RST = 4'd15;
   localparam logic [CSR_DATA_W-1:0] CHANNEL_MASK_RST  = 16'd7;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_ADAPT  = 2'd1,
      OP_INIT   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RATE_LIMIT    = 3'd0,
      CSR_POWER_LIMIT   = 3'd1,
      CSR_DEFAULT_POWER = 3'd2,
      CSR_EXCLUDED_RATE = 3'd3,
      CSR_CHANNEL_MASK  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_RATE,
      ST_POWER,
      ST_EMIT
   } state_type;

endpackage

[rtl/core/lora_adaptive_data_rate.sv]
// Adaptive data rate engine for one device.
// req channel: one transaction per operation. tuser carries the opcode
// (record, adapt, init) and the force flag; tdata carries the SNR and the
// current data rate. req_tready is high only while the engine is idle.
// Record and init are handled in the idle state and produce nothing. Adapt
// walks the SNR history with one shared adder, one entry per cycle, then
// steps the rate and the power index one unit per cycle with the same adder;
// no new transaction is taken until the engine is back in the idle state.
// rsp channel: one five-byte LinkADRReq per adapt that changed something or
// was forced, held in an output register until rsp_tready. A stalled
// receiver stalls only the final step of the next adapt that must emit.
// csr port: write-only registers, written whenever csr_wr_en is high; change
// them only while the engine is idle.
// Reset (synchronous): registers to their defaults, every history entry to
// -30 dB, write position to zero, power index to zero, no pending result.
module lora_adaptive_data_rate
   import ladr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // snr_value[7:0], current_rate[11:8], zero pad
   input  logic [REQ_USER_W-1:0]  req_tuser,  // opcode[1:0], force_command[2]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // command_id, rate_power_byte, mask_low,
                                              // mask_high, redundancy_byte
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type                    state_ff, state_in;
   logic [NIBBLE_W-1:0]          rate_limit_ff, power_limit_ff, default_power_ff;
   logic [NIBBLE_W-1:0]          excluded_rate_ff;
   logic [CSR_DATA_W-1:0]        channel_mask_ff;
   logic signed [SNR_W-1:0]      ring_ff [HISTORY_DEPTH];
   logic [RING_IDX_W-1:0]        ring_pos_ff, ring_pos_in;
   logic [NIBBLE_W-1:0]          power_ff, power_in;
   logic [NIBBLE_W-1:0]          orig_power_ff, orig_power_in;
   logic [NIBBLE_W-1:0]          rate_ff, rate_in;
   logic [NIBBLE_W-1:0]          orig_rate_ff, orig_rate_in;
   logic                         force_ff, force_in;
   logic [RING_IDX_W-1:0]        idx_ff, idx_in;
   logic signed [SNR_W-1:0]      hi_ff, hi_in, lo_ff, lo_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [MARGIN_W-1:0]   margin_ff, margin_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                         req_fire;
   opcode_type                   req_op;
   logic signed [SNR_W-1:0]      req_snr;
   logic                         ring_wr, ring_fill;
   logic signed [SNR_W-1:0]      scan_val;
   logic signed [MARGIN_W-1:0]   alu_a, alu_b, alu_sum;
   logic signed [SPREAD_W-1:0]   spread;
   logic                         changed;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = opcode_type'(req_tuser[1:0]);
   assign req_snr    = signed'(req_tdata[SNR_W-1:0]);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign scan_val   = ring_ff[idx_ff];
   assign spread     = SPREAD_W'(hi_ff) - SPREAD_W'(lo_ff);
   assign changed    = force_ff || (rate_ff != orig_rate_ff) || (power_ff != orig_power_ff);
   assign alu_sum    = alu_a + alu_b;

   always_comb begin
      alu_a = margin_ff;
      alu_b = -RATE_STEP;
      case (state_ff)
         ST_SCAN: begin
            alu_a = MARGIN_W'(sum_ff);
            alu_b = MARGIN_W'(scan_val);
         end
         ST_POWER: begin
            alu_b = -POWER_STEP;
         end
         default: begin
            alu_b = -RATE_STEP;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      ring_pos_in   = ring_pos_ff;
      power_in      = power_ff;
      orig_power_in = orig_power_ff;
      rate_in       = rate_ff;
      orig_rate_in  = orig_rate_ff;
      force_in      = force_ff;
      idx_in        = idx_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      sum_in        = sum_ff;
      margin_in     = margin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ring_wr       = 1'b0;
      ring_fill     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_RECORD: begin
                     ring_wr     = 1'b1;
                     ring_pos_in = (ring_pos_ff == RING_IDX_W'(HISTORY_DEPTH - 1)) ?
                                   '0 : ring_pos_ff + 1'b1;
                  end
                  OP_INIT: begin
                     ring_fill = 1'b1;
                     power_in  = default_power_ff;
                  end
                  OP_ADAPT: begin
                     rate_in       = req_tdata[SNR_W +: NIBBLE_W];
                     orig_rate_in  = req_tdata[SNR_W +: NIBBLE_W];
                     orig_power_in = power_ff;
                     force_in      = req_tuser[2];
                     idx_in        = '0;
                     hi_in         = HI_START;
                     lo_in         = LO_START;
                     sum_in        = '0;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_val > hi_ff) hi_in = scan_val;
            if (scan_val < lo_ff) lo_in = scan_val;
            sum_in = alu_sum[SUM_W-1:0];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == RING_IDX_W'(HISTORY_DEPTH - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            margin_in = {sum_ff, 1'b0};
            if (spread < SPREAD_LIMIT && rate_ff != excluded_rate_ff) begin
               state_in = ST_RATE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_RATE: begin
            if (rate_ff < rate_limit_ff && margin_ff > 0) begin
               rate_in   = rate_ff + 1'b1;
               margin_in = alu_sum;
            end else begin
               state_in = ST_POWER;
            end
         end
         ST_POWER: begin
            if (margin_ff > POWER_STEP && power_ff < power_limit_ff) begin
               power_in  = power_ff + 1'b1;
               margin_in = alu_sum;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!changed) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {REDUNDANCY, channel_mask_ff[15:8], channel_mask_ff[7:0],
                               rate_ff, power_ff, LINK_ADR_REQ};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ring_pos_ff  <= '0;
         power_ff     <= DEFAULT_POWER_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ring_pos_ff  <= ring_pos_in;
         power_ff     <= power_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      orig_power_ff <= orig_power_in;
      rate_ff       <= rate_in;
      orig_rate_ff  <= orig_rate_in;
      force_ff      <= force_in;
      idx_ff        <= idx_in;
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      sum_ff        <= sum_in;
      margin_ff     <= margin_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset || ring_fill) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            ring_ff[i] <= RING_FILL_SNR;
         end
      end else if (ring_wr) begin
         ring_ff[ring_pos_ff] <= req_snr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_limit_ff    <= RATE_LIMIT_RST;
         power_limit_ff   <= POWER_LIMIT_RST;
         default_power_ff <= DEFAULT_POWER_RST;
         excluded_rate_ff <= EXCLUDED_RATE_RST;
         channel_mask_ff  <= CHANNEL_MASK_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_RATE_LIMIT:    rate_limit_ff    <= csr_wdata[NIBBLE_W-1:0];
            CSR_POWER_LIMIT:   power_limit_ff   <= csr_wdata[NIBBLE_W-1:0];
            CSR_DEFAULT_POWER: default_power_ff <= csr_wdata[NIBBLE_W-1:0];
            CSR_EXCLUDED_RATE: excluded_rate_ff <= csr_wdata[NIBBLE_W-1:0];
            CSR_CHANNEL_MASK:  channel_mask_ff  <= csr_wdata;
            default: begin
               channel_mask_ff <= channel_mask_ff;
            end
         endcase
      end
   end

endmodule
